[design/ps2mct_pkg.sv]
package ps2mct_pkg;

    localparam int COORD_BITS = 12;
    localparam int CURSOR_W   = 12;
    localparam int SIZE_W     = 13;
    localparam int DELTA_W    = 9;
    localparam int SUM_W      = COORD_BITS + 2;
    localparam int CMP_W      = (SUM_W > SIZE_W + 1) ? SUM_W : SIZE_W + 1;
    localparam int CFG_IDX_W  = 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = 1;
    localparam int QCNT_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd1024;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd768;
    localparam logic [COORD_BITS-1:0] POS_X_RESET = COORD_BITS'(512);
    localparam logic [COORD_BITS-1:0] POS_Y_RESET = COORD_BITS'(384);

    localparam int HDR_SYNC_BIT  = 3;
    localparam int HDR_XSIGN_BIT = 4;
    localparam int HDR_YSIGN_BIT = 5;
    localparam int HDR_LEFT_BIT  = 0;

    typedef struct packed {
        logic                      move;
        logic                      left;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [COORD_BITS-1:0] clamp_coord(
        logic signed [SUM_W-1:0] v,
        logic [SIZE_W-1:0]       size
    );
        logic [CMP_W-1:0] lim;
        logic [CMP_W-1:0] top;
        logic [CMP_W-1:0] vu;
        lim = CMP_W'(size);
        top = CMP_W'(1) << COORD_BITS;
        vu  = CMP_W'($unsigned(v));
        if (size == '0)
            lim = CMP_W'(1);
        if (lim > top)
            lim = top;
        if (v < 0)
            return '0;
        if (vu >= lim)
            return COORD_BITS'(lim - CMP_W'(1));
        return COORD_BITS'(vu);
    endfunction

    function automatic logic [CURSOR_W-1:0] to_cursor(logic [COORD_BITS-1:0] p);
        logic [COORD_BITS+CURSOR_W-1:0] wide;
        wide = {{CURSOR_W{1'b0}}, p};
        return wide[CURSOR_W-1:0];
    endfunction

endpackage

[design/ps2mct_front.sv]
module ps2mct_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 q_full,
    input  logic                 aux_byte,
    input  logic [7:0]           data_byte,
    output logic                 push,
    output ps2mct_pkg::op_t      push_op
);
    import ps2mct_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_XDATA,
        PH_YDATA
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] header_reg, header_next;
    logic [7:0] xbyte_reg, xbyte_next;
    logic       accept;

    assign accept = in_valid && !q_full;
    assign push   = accept;

    always_comb
    begin
        phase_next   = phase_reg;
        header_next  = header_reg;
        xbyte_next   = xbyte_reg;
        push_op.move = 1'b0;
        push_op.left = header_reg[HDR_LEFT_BIT];
        push_op.dx   = $signed({header_reg[HDR_XSIGN_BIT], xbyte_reg});
        push_op.dy   = $signed({header_reg[HDR_YSIGN_BIT], data_byte});
        if (accept && aux_byte)
        begin
            case (phase_reg)
                PH_XDATA:
                begin
                    xbyte_next = data_byte;
                    phase_next = PH_YDATA;
                end
                PH_YDATA:
                begin
                    push_op.move = 1'b1;
                    phase_next   = PH_HEADER;
                end
                default:
                begin
                    header_next = data_byte;
                    phase_next  = data_byte[HDR_SYNC_BIT] ? PH_XDATA : PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            header_reg <= '0;
            xbyte_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
            xbyte_reg  <= xbyte_next;
        end
    end

endmodule

[design/ps2mct_queue.sv]
module ps2mct_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ps2mct_pkg::op_t       push_op,
    input  logic                  pop,
    output ps2mct_pkg::op_t       head_op,
    output ps2mct_pkg::q_status_t status
);
    import ps2mct_pkg::*;

    op_t               mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head_op      = mem[rd_ptr_reg];
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

endmodule

[design/ps2mct_back.sv]
module ps2mct_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ps2mct_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ps2mct_pkg::SIZE_W-1:0]        cfg_wdata,
    input  ps2mct_pkg::op_t                      head_op,
    input  logic                                 q_empty,
    output logic                                 pop,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [ps2mct_pkg::CURSOR_W-1:0]      cursor_x,
    output logic [ps2mct_pkg::CURSOR_W-1:0]      cursor_y,
    output logic                                 left_pressed,
    output logic                                 packet_done
);
    import ps2mct_pkg::*;

    logic [SIZE_W-1:0]     width_reg, height_reg;
    logic [COORD_BITS-1:0] pos_x_reg, pos_x_next;
    logic [COORD_BITS-1:0] pos_y_reg, pos_y_next;
    logic                  left_reg, left_next;
    logic                  out_valid_reg;
    logic [CURSOR_W-1:0]   cursor_x_reg, cursor_y_reg;
    logic                  left_out_reg, done_reg;
    logic signed [SUM_W-1:0] sum_x, sum_y;

    assign pop = !q_empty && (!out_valid_reg || !out_stall);

    assign sum_x = $signed({2'b00, pos_x_reg}) + SUM_W'(head_op.dx);
    assign sum_y = $signed({2'b00, pos_y_reg}) - SUM_W'(head_op.dy);

    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        left_next  = left_reg;
        if (head_op.move)
        begin
            pos_x_next = clamp_coord(sum_x, width_reg);
            pos_y_next = clamp_coord(sum_y, height_reg);
            left_next  = head_op.left;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_wdata;
                REG_SCREEN_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg     <= POS_X_RESET;
            pos_y_reg     <= POS_Y_RESET;
            left_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                pos_x_reg     <= pos_x_next;
                pos_y_reg     <= pos_y_next;
                left_reg      <= left_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cursor_x_reg <= to_cursor(pos_x_next);
            cursor_y_reg <= to_cursor(pos_y_next);
            left_out_reg <= left_next;
            done_reg     <= head_op.move;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cursor_x     = cursor_x_reg;
    assign cursor_y     = cursor_y_reg;
    assign left_pressed = left_out_reg;
    assign packet_done  = done_reg;

endmodule

[design/ps2_mouse_packet_cursor_tracker_top.sv]
// Channel  Handshake              Beat payload
// in       in_valid / in_stall    aux_byte, data_byte
// out      out_valid / out_stall  cursor_x, cursor_y, left_pressed, packet_done
// cfg      cfg_we                 cfg_index, cfg_wdata
//
// One byte per cycle while in_stall is low; its result passes the queue entry and then the
// output registers, and waits there while out_stall holds.
// Front tracks packet phase, a two-entry queue feeds the back end, which owns the
// cursor and clamps it on each movement beat.
// Reset: cursor 512/384, size 1024x768, expecting a header byte.
// in_stall rises only when the queue is full, i.e. when out_stall has held results back.
module ps2_mouse_packet_cursor_tracker_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ps2mct_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ps2mct_pkg::SIZE_W-1:0]        cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 aux_byte,
    input  logic [7:0]                           data_byte,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [ps2mct_pkg::CURSOR_W-1:0]      cursor_x,
    output logic [ps2mct_pkg::CURSOR_W-1:0]      cursor_y,
    output logic                                 left_pressed,
    output logic                                 packet_done
);
    import ps2mct_pkg::*;

    op_t       push_op, head_op;
    q_status_t q_stat;
    logic      push, pop;

    assign in_stall = q_stat.full;

    ps2mct_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .q_full    (q_stat.full),
        .aux_byte  (aux_byte),
        .data_byte (data_byte),
        .push      (push),
        .push_op   (push_op)
    );

    ps2mct_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .status  (q_stat)
    );

    ps2mct_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .head_op      (head_op),
        .q_empty      (q_stat.empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cursor_x     (cursor_x),
        .cursor_y     (cursor_y),
        .left_pressed (left_pressed),
        .packet_done  (packet_done)
    );

    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty at once");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    a_pop_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid)
        else $error("popped beat did not reach output");

endmodule

[verif/ps2mct_checker.sv]
`timescale 1ns / 1ps
module ps2mct_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ps2mct_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ps2mct_pkg::SIZE_W-1:0]     cfg_wdata,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              aux_byte,
    input  logic [7:0]                        data_byte,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [ps2mct_pkg::CURSOR_W-1:0]   cursor_x,
    input  logic [ps2mct_pkg::CURSOR_W-1:0]   cursor_y,
    input  logic                              left_pressed,
    input  logic                              packet_done,
    output int                                errors,
    output int                                pending
);
    import ps2mct_pkg::*;

    typedef enum logic [1:0] {WAIT_HEADER, WAIT_X, WAIT_Y} byte_slot_t;

    typedef struct packed {
        logic [CURSOR_W-1:0] x;
        logic [CURSOR_W-1:0] y;
        logic                left;
        logic                done;
    } cursor_beat_t;

    logic [SIZE_W-1:0]     width_q;
    logic [SIZE_W-1:0]     height_q;
    byte_slot_t            slot;
    logic [7:0]            header_q;
    logic [7:0]            x_raw_q;
    logic [COORD_BITS-1:0] x_pos;
    logic [COORD_BITS-1:0] y_pos;
    logic                  left_q;
    cursor_beat_t          expected_beats[$];
    cursor_beat_t          want;
    int                    mismatches = 0;

    assign errors = mismatches;

    task report_mismatch(input string what, input int got, input int exp_val);
        $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, exp_val);
        mismatches++;
    endtask

    function automatic logic [COORD_BITS-1:0] clamp_to_screen(int v, logic [SIZE_W-1:0] size);
        int lim;
        lim = (size == '0) ? 1 : int'(size);
        if (lim > (1 << COORD_BITS))
            lim = 1 << COORD_BITS;
        if (v < 0)
            return '0;
        if (v >= lim)
            return COORD_BITS'(lim - 1);
        return COORD_BITS'(v);
    endfunction

    function automatic int movement(logic [7:0] raw, logic neg);
        return neg ? int'(raw) - 256 : int'(raw);
    endfunction

    function void track_byte(logic aux, logic [7:0] data);
        cursor_beat_t beat;
        beat.done = 1'b0;
        if (aux) begin
            case (slot)
                WAIT_X:
                begin
                    x_raw_q = data;
                    slot    = WAIT_Y;
                end
                WAIT_Y:
                begin
                    left_q = header_q[HDR_LEFT_BIT];
                    x_pos  = clamp_to_screen(int'(x_pos)
                             + movement(x_raw_q, header_q[HDR_XSIGN_BIT]), width_q);
                    y_pos  = clamp_to_screen(int'(y_pos)
                             - movement(data, header_q[HDR_YSIGN_BIT]), height_q);
                    slot      = WAIT_HEADER;
                    beat.done = 1'b1;
                end
                default:
                begin
                    header_q = data;
                    slot     = data[HDR_SYNC_BIT] ? WAIT_X : WAIT_HEADER;
                end
            endcase
        end
        beat.x    = CURSOR_W'(x_pos);
        beat.y    = CURSOR_W'(y_pos);
        beat.left = left_q;
        expected_beats.push_back(beat);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            width_q  = WIDTH_RESET;
            height_q = HEIGHT_RESET;
            slot     = WAIT_HEADER;
            header_q = '0;
            x_raw_q  = '0;
            x_pos    = POS_X_RESET;
            y_pos    = POS_Y_RESET;
            left_q   = 1'b0;
            expected_beats.delete();
            pending  = 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end
                else begin
                    want = expected_beats.pop_front();
                    if (cursor_x !== want.x)
                        report_mismatch("cursor_x", cursor_x, want.x);
                    if (cursor_y !== want.y)
                        report_mismatch("cursor_y", cursor_y, want.y);
                    if (left_pressed !== want.left)
                        report_mismatch("left_pressed", left_pressed, want.left);
                    if (packet_done !== want.done)
                        report_mismatch("packet_done", packet_done, want.done);
                end
            end
            if (cfg_we) begin
                if (cfg_index == REG_SCREEN_WIDTH)
                    width_q = cfg_wdata;
                else if (cfg_index == REG_SCREEN_HEIGHT)
                    height_q = cfg_wdata;
            end
            if (in_valid && !in_stall)
                track_byte(aux_byte, data_byte);
            pending = expected_beats.size();
        end
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
module testbench;
    import ps2mct_pkg::*;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_SCREEN_WIDTH;
    logic [SIZE_W-1:0]    cfg_wdata = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic                 aux_byte  = 1'b0;
    logic [7:0]           data_byte = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [CURSOR_W-1:0]  cursor_x;
    logic [CURSOR_W-1:0]  cursor_y;
    logic                 left_pressed;
    logic                 packet_done;
    int                   errors;
    int                   pending;

    int                   mouse_bytes = 0;
    bit                   quiet       = 1'b0;
    bit                   eager       = 1'b0;
    bit                   hold_now    = 1'b0;

    ps2_mouse_packet_cursor_tracker_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .aux_byte     (aux_byte),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cursor_x     (cursor_x),
        .cursor_y     (cursor_y),
        .left_pressed (left_pressed),
        .packet_done  (packet_done)
    );

    ps2mct_checker tracker_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    function int pick_gap();
        int r;
        if (quiet || eager)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        int run_left;
        int r;
        run_left = 0;
        forever begin
            @(negedge clk);
            if (hold_now) begin
                out_stall <= 1'b1;
                repeat (80) @(negedge clk);
                hold_now = 1'b0;
                run_left = 0;
            end
            else if (quiet) begin
                out_stall <= 1'b0;
            end
            else if (run_left > 0) begin
                run_left--;
            end
            else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    out_stall <= 1'b0;
                    run_left = $urandom_range(0, 8);
                end
                else if (r < 92) begin
                    out_stall <= 1'b1;
                    run_left = $urandom_range(0, 3);
                end
                else begin
                    out_stall <= 1'b1;
                    run_left = $urandom_range(10, 40);
                end
            end
        end
    end

    task send_byte(input logic aux, input logic [7:0] data);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        aux_byte  <= aux;
        data_byte <= data;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // mouse byte, now and then preceded by a keyboard byte
    task send_mouse(input logic [7:0] data);
        if ($urandom_range(0, 15) == 0)
            send_byte(1'b0, 8'($urandom));
        send_byte(1'b1, data);
        mouse_bytes++;
    endtask

    task random_traffic(input int n);
        int target;
        int r;
        target = mouse_bytes + n;
        while (mouse_bytes < target) begin
            r = $urandom_range(0, 19);
            if (r < 14) begin
                send_mouse(8'($urandom) | 8'h08);
                send_mouse(8'($urandom));
                send_mouse(8'($urandom));
            end
            else if (r < 16) begin
                send_byte(1'b0, 8'($urandom));
            end
            else if (r < 18) begin
                send_mouse(8'($urandom) & 8'hF7);
            end
            else begin
                send_mouse(8'($urandom) | 8'h08);
                send_mouse(8'($urandom));
            end
        end
    endtask

    task drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task set_screen(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_SCREEN_WIDTH;
        cfg_wdata <= w;
        @(negedge clk);
        cfg_index <= REG_SCREEN_HEIGHT;
        cfg_wdata <= h;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // keyboard byte, dropped headers, then packets at the sign and overflow extremes
        send_byte(1'b0, 8'hFF);
        send_byte(1'b1, 8'h00);
        send_byte(1'b1, 8'hF7);
        send_byte(1'b1, 8'h09);
        send_byte(1'b1, 8'hFF);
        send_byte(1'b1, 8'hFF);
        send_byte(1'b1, 8'h08);
        send_byte(1'b0, 8'h5A);
        send_byte(1'b1, 8'h00);
        send_byte(1'b0, 8'hA5);
        send_byte(1'b1, 8'h00);
        send_byte(1'b1, 8'h38);
        send_byte(1'b1, 8'h00);
        send_byte(1'b1, 8'h00);
        send_byte(1'b1, 8'hF9);
        send_byte(1'b1, 8'h01);
        send_byte(1'b1, 8'h80);
        send_byte(1'b1, 8'h28);
        send_byte(1'b1, 8'h7F);
        send_byte(1'b1, 8'h80);
        send_byte(1'b1, 8'h18);
        send_byte(1'b1, 8'h80);
        send_byte(1'b1, 8'h7F);

        random_traffic(200);

        set_screen(13'd1, 13'd1);
        random_traffic(150);

        set_screen(13'd4096, 13'd4096);
        quiet = 1'b1;
        random_traffic(250);
        quiet = 1'b0;

        set_screen(13'd0, 13'd0);
        random_traffic(150);

        set_screen(13'd8191, 13'd8191);
        random_traffic(200);

        set_screen(13'd640, 13'd480);
        eager = 1'b1;
        @(posedge clk);
        hold_now = 1'b1;
        random_traffic(250);
        eager = 1'b0;

        set_screen(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)));
        random_traffic(250);

        drain();
        repeat (10) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
